### hw/rtl/exhaustive_tour_search_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the exhaustive tour search core
// Each macro expands to one labelled concurrent assertion. It is clocked on
// clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef EXHAUSTIVE_TOUR_SEARCH_CORE_ASSERT_SVH
`define EXHAUSTIVE_TOUR_SEARCH_CORE_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define ETS_ASSERT_IMP(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("exhaustive_tour_search_core: same-cycle check failed");

// The property must hold in the cycle after the condition.
`define ETS_ASSERT_NXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("exhaustive_tour_search_core: next-cycle check failed");

`endif

### hw/rtl/ets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_pkg
// Shared constants and types of the exhaustive tour search core.
// ----------------------------------------------------------------------------
package ets_pkg;

   localparam int MAX_CITIES    = 16;
   localparam int CITY_BITS     = 4;
   localparam int COUNT_BITS    = CITY_BITS + 1;
   localparam int DIST_BITS     = 16;
   localparam int EDGE_BITS     = 16;
   localparam int COST_BITS     = 21;
   localparam int OUT_COST_BITS = 20;
   localparam int MEM_DEPTH     = MAX_CITIES * MAX_CITIES;
   localparam int MEM_ADDR_BITS = 2 * CITY_BITS;

   localparam logic [COUNT_BITS-1:0] CITY_COUNT_RESET = COUNT_BITS'(4);

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_SOLVE = 1'b1;

   // Distance memory read address selection.
   localparam logic ADDR_STEP   = 1'b0;
   localparam logic ADDR_RETURN = 1'b1;

   typedef struct packed {
      logic load;
      logic start;
      logic next_cand;
      logic backtrack;
      logic descend;
      logic commit;
      logic addr_sel;
      logic slot_next;
   } ets_cmd_type;

   typedef struct packed {
      logic cand_ge_n;
      logic cand_visited;
      logic level_is_one;
      logic level_last;
      logic prune;
      logic better;
      logic n_is_one;
      logic slot_last;
   } ets_status_type;

endpackage

### hw/rtl/ets_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_ctrl
// Sequencer of the tour search: request intake, depth-first walk, output.
// ----------------------------------------------------------------------------
module ets_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_type,
   input  logic                   rsp_stall,
   input  ets_pkg::ets_status_type status,
   output ets_pkg::ets_cmd_type   cmd,
   output logic                   req_stall,
   output logic                   rsp_valid
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TRY  = 3'd1;
   localparam logic [2:0] ST_EVAL = 3'd2;
   localparam logic [2:0] ST_RET  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == ets_pkg::REQ_SOLVE) begin
                  cmd.start = 1'b1;
                  state_in  = status.n_is_one ? ST_EMIT : ST_TRY;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_TRY: begin
            cmd.addr_sel = ets_pkg::ADDR_STEP;
            if (status.cand_ge_n) begin
               if (status.level_is_one) begin
                  state_in = ST_EMIT;
               end else begin
                  cmd.backtrack = 1'b1;
               end
            end else if (status.cand_visited) begin
               cmd.next_cand = 1'b1;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.prune) begin
               cmd.next_cand = 1'b1;
               state_in      = ST_TRY;
            end else if (status.level_last) begin
               cmd.addr_sel = ets_pkg::ADDR_RETURN;
               state_in     = ST_RET;
            end else begin
               cmd.descend = 1'b1;
               state_in    = ST_TRY;
            end
         end
         ST_RET: begin
            cmd.commit    = status.better;
            cmd.next_cand = 1'b1;
            state_in      = ST_TRY;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (status.slot_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.slot_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

endmodule

### hw/rtl/ets_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_dpath
// Distance memory, search stack, best tour and output slot counter.
// ----------------------------------------------------------------------------
`include "exhaustive_tour_search_core_assert.svh"

module ets_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [ets_pkg::COUNT_BITS-1:0]         csr_wr_data,
   input  logic [ets_pkg::CITY_BITS-1:0]          req_from_city,
   input  logic [ets_pkg::CITY_BITS-1:0]          req_to_city,
   input  logic [ets_pkg::EDGE_BITS-1:0]          req_edge_length,
   input  ets_pkg::ets_cmd_type                   cmd,
   output ets_pkg::ets_status_type                status,
   output logic [ets_pkg::CITY_BITS-1:0]          rsp_tour_slot,
   output logic [ets_pkg::CITY_BITS-1:0]          rsp_tour_city,
   output logic [ets_pkg::OUT_COST_BITS-1:0]      rsp_tour_cost,
   output logic                                   rsp_last_slot
);

   localparam int CB = ets_pkg::CITY_BITS;
   localparam int NB = ets_pkg::COUNT_BITS;
   localparam int KB = ets_pkg::COST_BITS;
   localparam int NC = ets_pkg::MAX_CITIES;

   // Symmetric pairs share one entry, held at {larger city, smaller city}.
   function automatic logic [ets_pkg::MEM_ADDR_BITS-1:0] pair_addr(
      input logic [CB-1:0] a,
      input logic [CB-1:0] b
   );
      logic [ets_pkg::MEM_ADDR_BITS-1:0] addr;
      addr = (a > b) ? {a, b} : {b, a};
      return addr;
   endfunction

   logic [NB-1:0]                     city_count_ff;
   logic [NB-1:0]                     city_count_in;
   logic [NB-1:0]                     n_eff;

   logic [ets_pkg::DIST_BITS-1:0]     dist_mem [ets_pkg::MEM_DEPTH];
   logic [ets_pkg::DIST_BITS-1:0]     rd_data_ff;
   logic [ets_pkg::MEM_ADDR_BITS-1:0] rd_addr;
   logic [ets_pkg::MEM_ADDR_BITS-1:0] wr_addr;
   logic                              wr_en;

   logic [CB-1:0] order_ff      [NC];
   logic [CB-1:0] order_in      [NC];
   logic [KB-1:0] cost_ff       [NC];
   logic [KB-1:0] cost_in       [NC];
   logic [CB-1:0] best_order_ff [NC];
   logic [CB-1:0] best_order_in [NC];

   logic [NC-1:0] visited_ff;
   logic [NC-1:0] visited_in;
   logic [CB-1:0] level_ff;
   logic [CB-1:0] level_in;
   logic [NB-1:0] cand_ff;
   logic [NB-1:0] cand_in;
   logic [KB-1:0] sum_ff;
   logic [KB-1:0] sum_in;
   logic [KB-1:0] best_ff;
   logic [KB-1:0] best_in;
   logic [CB-1:0] slot_ff;
   logic [CB-1:0] slot_in;

   logic [CB-1:0] level_prev;
   logic [CB-1:0] prev_city;
   logic [KB:0]   step_sum;
   logic [KB:0]   ret_sum;

   // Out-of-range counts are clamped into 1..MAX_CITIES.
   always_comb begin
      if (city_count_ff == '0) begin
         n_eff = NB'(1);
      end else if (city_count_ff > NB'(NC)) begin
         n_eff = NB'(NC);
      end else begin
         n_eff = city_count_ff;
      end
   end

   assign city_count_in = csr_wr_en ? csr_wr_data : city_count_ff;

   assign level_prev = level_ff - CB'(1);
   assign prev_city  = order_ff[level_prev];
   assign step_sum   = {1'b0, cost_ff[level_ff]} + (KB + 1)'(rd_data_ff);
   assign ret_sum    = {1'b0, sum_ff} + (KB + 1)'(rd_data_ff);
   assign sum_in     = step_sum[KB-1:0];

   assign rd_addr = (cmd.addr_sel == ets_pkg::ADDR_RETURN) ?
                    {cand_ff[CB-1:0], CB'(0)} : pair_addr(prev_city, cand_ff[CB-1:0]);
   assign wr_addr = pair_addr(req_from_city, req_to_city);
   assign wr_en   = cmd.load && (req_from_city != req_to_city);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_mem[wr_addr] <= req_edge_length[ets_pkg::DIST_BITS-1:0];
      end
      rd_data_ff <= dist_mem[rd_addr];
   end

   always_comb begin
      order_in      = order_ff;
      cost_in       = cost_ff;
      best_order_in = best_order_ff;
      visited_in    = visited_ff;
      level_in      = level_ff;
      cand_in       = cand_ff;
      best_in       = best_ff;
      slot_in       = slot_ff;

      if (cmd.start) begin
         visited_in       = NC'(1);
         level_in         = CB'(1);
         cand_in          = NB'(1);
         order_in[0]      = '0;
         cost_in[1]       = '0;
         best_order_in[0] = '0;
         best_in          = (n_eff == NB'(1)) ? '0 : '1;
         slot_in          = '0;
      end
      if (cmd.next_cand) begin
         cand_in = cand_ff + NB'(1);
      end
      if (cmd.backtrack) begin
         level_in                        = level_prev;
         cand_in                         = NB'(order_ff[level_prev]) + NB'(1);
         visited_in[order_ff[level_prev]] = 1'b0;
      end
      if (cmd.descend) begin
         order_in[level_ff]             = cand_ff[CB-1:0];
         visited_in[cand_ff[CB-1:0]]    = 1'b1;
         cost_in[level_ff + CB'(1)]     = step_sum[KB-1:0];
         level_in                       = level_ff + CB'(1);
         cand_in                        = NB'(1);
      end
      if (cmd.commit) begin
         best_in = ret_sum[KB-1:0];
         for (int k = 0; k < NC; k++) begin
            if (CB'(k) < level_ff) begin
               best_order_in[k] = order_ff[k];
            end else if (CB'(k) == level_ff) begin
               best_order_in[k] = cand_ff[CB-1:0];
            end
         end
      end
      if (cmd.slot_next) begin
         slot_in = slot_ff + CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= ets_pkg::CITY_COUNT_RESET;
         visited_ff    <= '0;
         level_ff      <= '0;
         cand_ff       <= '0;
         best_ff       <= '1;
         slot_ff       <= '0;
      end else begin
         city_count_ff <= city_count_in;
         visited_ff    <= visited_in;
         level_ff      <= level_in;
         cand_ff       <= cand_in;
         best_ff       <= best_in;
         slot_ff       <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff      <= order_in;
      cost_ff       <= cost_in;
      best_order_ff <= best_order_in;
      sum_ff        <= sum_in;
   end

   assign status.cand_ge_n    = (cand_ff >= n_eff);
   assign status.cand_visited = visited_ff[cand_ff[CB-1:0]];
   assign status.level_is_one = (level_ff == CB'(1));
   assign status.level_last   = ({1'b0, level_ff} == (n_eff - NB'(1)));
   assign status.prune        = (step_sum >= {1'b0, best_ff});
   assign status.better       = (ret_sum < {1'b0, best_ff});
   assign status.n_is_one     = (n_eff == NB'(1));
   assign status.slot_last    = ({1'b0, slot_ff} == (n_eff - NB'(1)));

   assign rsp_tour_slot = slot_ff;
   assign rsp_tour_city = best_order_ff[slot_ff];
   assign rsp_tour_cost = best_ff[KB-1] ? '1 : best_ff[ets_pkg::OUT_COST_BITS-1:0];
   assign rsp_last_slot = status.slot_last;

   // A partial path is extended only when it is still cheaper than the best tour.
   `ETS_ASSERT_IMP(a_descend_cheaper, cmd.descend, !status.prune && !status.level_last)
   // A new best is taken only for a complete tour that beats the old one.
   `ETS_ASSERT_IMP(a_commit_better, cmd.commit, status.level_last && status.better)
   // Stepping back never drops the start city from the visited set.
   `ETS_ASSERT_NXT(a_start_kept, cmd.backtrack, visited_ff[0])

endmodule

### hw/rtl/exhaustive_tour_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exhaustive_tour_search_core
// Brute-force travelling salesman search over up to sixteen cities.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Fields
//   req      in         req_valid, req_stall   type, from_city, to_city, edge_length
//   rsp      out        rsp_valid, rsp_stall   tour_slot, tour_city, tour_cost, last_slot
//   csr      in         csr_wr_en              csr_wr_data (city count)
//
// A load request writes one distance pair. A solve request walks every tour from
// city 0 in lexicographic order, skipping visited candidates, stepping back, and
// trying edges and closing tours through the one memory read port and adder.
// Paths already costing at least the best tour are cut off; the best tour is then
// emitted city by city, paced by rsp_stall. Reset is synchronous and leaves the
// distance memory uncleared; req_stall is high from a solve until its last response.
//
// The search is a depth-first walk over a visited set. The controller picks
// the next candidate city, fetches the edge from the previous city, and
// either prunes, goes one level deeper, or closes the tour with the return
// edge to city 0. A complete tour replaces the best one only when it is
// strictly cheaper, so the first optimal tour in lexicographic order wins.
// ----------------------------------------------------------------------------
module exhaustive_tour_search_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ets_pkg::COUNT_BITS-1:0]      csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [ets_pkg::CITY_BITS-1:0]       req_from_city,
   input  logic [ets_pkg::CITY_BITS-1:0]       req_to_city,
   input  logic [ets_pkg::EDGE_BITS-1:0]       req_edge_length,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ets_pkg::CITY_BITS-1:0]       rsp_tour_slot,
   output logic [ets_pkg::CITY_BITS-1:0]       rsp_tour_city,
   output logic [ets_pkg::OUT_COST_BITS-1:0]   rsp_tour_cost,
   output logic                                rsp_last_slot
);

   ets_pkg::ets_cmd_type    cmd;
   ets_pkg::ets_status_type status;

   // The controller decides each step; the datapath carries it out.
   ets_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   // Distance memory, search stack, best tour and output counter.
   ets_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_from_city   (req_from_city),
      .req_to_city     (req_to_city),
      .req_edge_length (req_edge_length),
      .cmd             (cmd),
      .status          (status),
      .rsp_tour_slot   (rsp_tour_slot),
      .rsp_tour_city   (rsp_tour_city),
      .rsp_tour_cost   (rsp_tour_cost),
      .rsp_last_slot   (rsp_last_slot)
   );

endmodule

### tb/tb_exhaustive_tour_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exhaustive_tour_search_core
// Self-checking testbench for the brute-force tour search core.
// Distance pairs are loaded and solves are issued over the request channel.
// Every accepted request updates a local predictor. The predictor keeps its
// own copy of the distance store and finds the first cheapest closed tour in
// lexicographic order by a pruned depth-first search. Each tour city that
// comes back is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_exhaustive_tour_search_core;

   // Random traffic is sized by useful requests; diagonal writes are not counted.
   localparam int     RANDOM_REQUESTS = 145;
   localparam longint CYCLE_LIMIT     = 2_000_000;
   localparam int     SETTLE_CYCLES   = 4;
   localparam int     LONG_HOLD       = 2000;
   localparam int     PRINT_CAP       = 40;

   // Ways of choosing edge lengths for one batch of distance loads.
   typedef enum int {
      LEN_WIDE,
      LEN_TIES,
      LEN_EXTREME
   } len_mode_type;

   // One city of a predicted best tour, as the response channel shows it.
   typedef struct {
      logic [ets_pkg::CITY_BITS-1:0]     slot;
      logic [ets_pkg::CITY_BITS-1:0]     city;
      logic [ets_pkg::OUT_COST_BITS-1:0] cost;
      logic                              last;
   } tour_step_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_wr_en;
   logic [ets_pkg::COUNT_BITS-1:0]    csr_wr_data;
   logic                              req_valid;
   logic                              req_stall;
   logic                              req_type;
   logic [ets_pkg::CITY_BITS-1:0]     req_from_city;
   logic [ets_pkg::CITY_BITS-1:0]     req_to_city;
   logic [ets_pkg::EDGE_BITS-1:0]     req_edge_length;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [ets_pkg::CITY_BITS-1:0]     rsp_tour_slot;
   logic [ets_pkg::CITY_BITS-1:0]     rsp_tour_city;
   logic [ets_pkg::OUT_COST_BITS-1:0] rsp_tour_cost;
   logic                              rsp_last_slot;

   // Predictor state: the distance store, the city count register, and the
   // working arrays of the tour search.
   logic [ets_pkg::EDGE_BITS-1:0] road_len [0:15][0:15];
   int                            city_count_reg;
   int                            tour_len;
   int                            trail      [0:15];
   int                            best_trail [0:15];
   longint                        best_cost;

   tour_step_type pending_tour_steps[$];

   // Pacing of both sides, and the long receiver hold-off.
   int send_idle_pct;
   int stall_pct;
   int hold_left;

   // Run statistics.
   longint cycle_count;
   int     fault_count;
   int     useful_requests;
   int     solves_issued;
   int     tour_steps_checked;

   exhaustive_tour_search_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_from_city   (req_from_city),
      .req_to_city     (req_to_city),
      .req_edge_length (req_edge_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tour_slot   (rsp_tour_slot),
      .rsp_tour_city   (rsp_tour_city),
      .rsp_tour_cost   (rsp_tour_cost),
      .rsp_last_slot   (rsp_last_slot)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // The diagonal always reads as zero, whatever was written to it.
   function automatic longint road(input int a, input int b);
      return (a == b) ? 0 : longint'(road_len[a][b]);
   endfunction

   // Depth-first walk over tours that start at city 0, trying cities in
   // ascending order. A tour replaces the best only when strictly cheaper, so
   // the first optimal tour in lexicographic order survives. Cutting off a
   // partial path that already costs at least the best is safe, because edge
   // lengths are never negative.
   function automatic void explore(input int depth, input int here, input longint so_far,
                                   input logic [15:0] seen);
      longint closed;
      if (so_far >= best_cost)
         return;
      if (depth == tour_len) begin
         closed = so_far + road(here, 0);
         if (closed < best_cost) begin
            best_cost = closed;
            for (int k = 0; k < tour_len; k++)
               best_trail[k] = trail[k];
         end
         return;
      end
      for (int c = 1; c < tour_len; c++) begin
         if (!seen[c]) begin
            trail[depth] = c;
            explore(depth + 1, c, so_far + road(here, c), seen | (16'h1 << c));
         end
      end
   endfunction

   // Works out the whole emitted tour for a solve and queues it city by city.
   function automatic void predict_best_tour();
      tour_step_type step;
      int            n;
      n = (city_count_reg < 1) ? 1 : ((city_count_reg > ets_pkg::MAX_CITIES) ?
                                      ets_pkg::MAX_CITIES : city_count_reg);
      tour_len      = n;
      best_cost     = longint'(1) << 40;
      trail[0]      = 0;
      best_trail[0] = 0;
      explore(1, 0, 0, 16'h0001);
      for (int k = 0; k < n; k++) begin
         step.slot = ets_pkg::CITY_BITS'(k);
         step.city = ets_pkg::CITY_BITS'(best_trail[k]);
         step.cost = (best_cost > longint'(20'hFFFFF)) ? 20'hFFFFF : best_cost[19:0];
         step.last = (k == n - 1);
         pending_tour_steps.push_back(step);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      if (fault_count < PRINT_CAP)
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      fault_count++;
   endtask

   // Outputs are sampled at the rising edge; rsp_stall was set up at the
   // falling edge before, so a response is taken exactly when both agree.
   always @(posedge clock) begin : check_tour_steps
      tour_step_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         tour_steps_checked++;
         if (pending_tour_steps.size() == 0) begin
            report_mismatch($sformatf("unexpected response slot %0d city %0d cost %0d",
                                      rsp_tour_slot, rsp_tour_city, rsp_tour_cost));
         end else begin
            want = pending_tour_steps.pop_front();
            if (rsp_tour_slot !== want.slot)
               report_mismatch($sformatf("tour_slot %0d, predicted %0d",
                                         rsp_tour_slot, want.slot));
            if (rsp_tour_city !== want.city)
               report_mismatch($sformatf("slot %0d tour_city %0d, predicted %0d",
                                         want.slot, rsp_tour_city, want.city));
            if (rsp_tour_cost !== want.cost)
               report_mismatch($sformatf("slot %0d tour_cost %0d, predicted %0d",
                                         want.slot, rsp_tour_cost, want.cost));
            if (rsp_last_slot !== want.last)
               report_mismatch($sformatf("slot %0d last_slot %0b, predicted %0b",
                                         want.slot, rsp_last_slot, want.last));
         end
      end
   end

   // The watchdog ends a run that has hung or run far beyond its budget.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out with %0d tour cities still outstanding",
                  pending_tour_steps.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // The receiver either serves a long hold-off, counted down here, or
   // stalls at random at the rate of the current phase.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   // Offers one request from the next falling edge, after any random idle
   // cycles, and holds it until the block takes it. The predictor is updated
   // at the edge of acceptance. Valid is left high: the caller either sends
   // the next request or lowers it through sender_quiet.
   task automatic send_request(input logic kind, input int a, input int b, input int len);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_from_city   <= ets_pkg::CITY_BITS'(a);
      req_to_city     <= ets_pkg::CITY_BITS'(b);
      req_edge_length <= ets_pkg::EDGE_BITS'(len);
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (kind == ets_pkg::REQ_SOLVE) begin
         solves_issued++;
         useful_requests++;
         predict_best_tour();
      end else if (a != b) begin
         useful_requests++;
         road_len[a][b] = ets_pkg::EDGE_BITS'(len);
         road_len[b][a] = ets_pkg::EDGE_BITS'(len);
      end
   endtask

   task automatic send_solve();
      send_request(ets_pkg::REQ_SOLVE, $urandom_range(15), $urandom_range(15),
                   $urandom_range(65535));
   endtask

   task automatic sender_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // The sender pauses until every predicted tour city has come back.
   task automatic wait_for_tours();
      sender_quiet();
      while (pending_tour_steps.size() != 0)
         @(posedge clock);
   endtask

   // The register is only written with the block idle. A final load may
   // still be in flight after the last response, so SETTLE_CYCLES pass first.
   task automatic set_city_count(input int value);
      wait_for_tours();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ets_pkg::COUNT_BITS'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      city_count_reg = value;
   endtask

   function automatic int pick_length(input len_mode_type mode);
      case (mode)
         LEN_WIDE: begin
            return $urandom_range(65535);
         end
         LEN_TIES: begin
            return $urandom_range(3);
         end
         default: begin
            if ($urandom_range(1))
               return $urandom_range(1) ? 65535 : 0;
            return $urandom_range(65535);
         end
      endcase
   endfunction

   // Writes every pair among the first n cities in shuffled order and random
   // orientation, with stray diagonal writes and writes to unused cities mixed
   // in. Every pair a solve will read is therefore written before it.
   task automatic load_all_pairs(input int n, input len_mode_type mode);
      int pair_a[$];
      int pair_b[$];
      int j;
      int swap_tmp;
      int x;
      for (int a = 0; a < n; a++)
         for (int b = a + 1; b < n; b++) begin
            pair_a.push_back(a);
            pair_b.push_back(b);
         end
      for (int k = pair_a.size() - 1; k > 0; k--) begin
         j = $urandom_range(k);
         swap_tmp = pair_a[k]; pair_a[k] = pair_a[j]; pair_a[j] = swap_tmp;
         swap_tmp = pair_b[k]; pair_b[k] = pair_b[j]; pair_b[j] = swap_tmp;
      end
      for (int k = 0; k < pair_a.size(); k++) begin
         if ($urandom_range(99) < 15) begin
            x = $urandom_range(15);
            if ($urandom_range(1) || n >= ets_pkg::MAX_CITIES)
               send_request(ets_pkg::REQ_LOAD, x, x, $urandom_range(65535));
            else if (x != n)
               send_request(ets_pkg::REQ_LOAD, n + $urandom_range(15 - n), x,
                            $urandom_range(65535));
         end
         if ($urandom_range(1))
            send_request(ets_pkg::REQ_LOAD, pair_a[k], pair_b[k], pick_length(mode));
         else
            send_request(ets_pkg::REQ_LOAD, pair_b[k], pair_a[k], pick_length(mode));
      end
      // Now and then a pair is written again, so that the later value wins.
      if (pair_a.size() != 0 && $urandom_range(3) == 0) begin
         j = $urandom_range(pair_a.size() - 1);
         send_request(ets_pkg::REQ_LOAD, pair_a[j], pair_b[j], pick_length(mode));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Right after reset the city count is four. The loads cover the extremes
   // of every field, a pair given in both orientations, and diagonal writes
   // that must leave the zero diagonal alone.
   task automatic test_reset_count_solve();
      send_request(ets_pkg::REQ_LOAD, 0, 1, 65535);
      send_request(ets_pkg::REQ_LOAD, 2, 0, 0);
      send_request(ets_pkg::REQ_LOAD, 1, 2, 7);
      send_request(ets_pkg::REQ_LOAD, 3, 0, 65535);
      send_request(ets_pkg::REQ_LOAD, 1, 3, 12);
      send_request(ets_pkg::REQ_LOAD, 3, 2, 5);
      send_request(ets_pkg::REQ_LOAD, 15, 15, 65535);
      send_request(ets_pkg::REQ_LOAD, 3, 3, 1234);
      send_request(ets_pkg::REQ_LOAD, 0, 15, 0);
      send_request(ets_pkg::REQ_LOAD, 15, 0, 43690);
      send_request(ets_pkg::REQ_LOAD, 2, 2, 0);
      send_solve();
   endtask

   // With every edge equal all tours tie and the first, 0-1-2-3, must win.
   // Lengthening one edge then moves the winner to the first tour avoiding it.
   task automatic test_tie_order();
      for (int a = 0; a < 4; a++)
         for (int b = a + 1; b < 4; b++)
            send_request(ets_pkg::REQ_LOAD, b, a, 9);
      send_solve();
      send_request(ets_pkg::REQ_LOAD, 1, 0, 10);
      send_solve();
   endtask

   // A ring of unit edges among all sixteen cities, every other edge at the
   // maximum, keeps the sixteen-city search short through pruning. The count
   // register is taken to its top, beyond the top, to zero and back.
   task automatic test_count_extremes();
      send_idle_pct = 25;
      stall_pct     = 25;
      for (int a = 0; a < ets_pkg::MAX_CITIES; a++)
         for (int b = a + 1; b < ets_pkg::MAX_CITIES; b++) begin
            if ($urandom_range(1))
               send_request(ets_pkg::REQ_LOAD, a, b,
                            (b == a + 1 || (a == 0 && b == ets_pkg::MAX_CITIES - 1)) ?
                            1 : 65535);
            else
               send_request(ets_pkg::REQ_LOAD, b, a,
                            (b == a + 1 || (a == 0 && b == ets_pkg::MAX_CITIES - 1)) ?
                            1 : 65535);
         end
      set_city_count(ets_pkg::MAX_CITIES);
      send_solve();
      set_city_count(31);
      send_solve();
      set_city_count(0);
      send_solve();
      set_city_count(1);
      send_solve();
      set_city_count(2);
      send_solve();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // The receiver holds off for a long stretch while the sender keeps going,
   // so loads and a second solve queue up behind the first solve.
   task automatic test_backpressure();
      int a;
      set_city_count(5);
      load_all_pairs(5, LEN_WIDE);
      hold_left = LONG_HOLD;
      send_solve();
      repeat (4) begin
         a = $urandom_range(4);
         send_request(ets_pkg::REQ_LOAD, a, (a + 1 + $urandom_range(3)) % 5,
                      $urandom_range(65535));
      end
      send_solve();
      wait_for_tours();
   endtask

   // Well-formed batches: a full set of pairs for some city count, then a
   // solve. The count changes between some batches only, so that loads also
   // arrive while a solve is still busy. Pacing moves through four phases.
   task automatic test_random_traffic();
      int start_count;
      int phase;
      int cities;
      int active_cities;
      int pick;
      start_count   = useful_requests;
      active_cities = 2;
      set_city_count(2);
      while (useful_requests - start_count < RANDOM_REQUESTS) begin
         phase = (useful_requests - start_count) * 4 / RANDOM_REQUESTS;
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 70; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         cities = active_cities;
         if ($urandom_range(2) == 0) begin
            pick = $urandom_range(99);
            cities = (pick < 5) ? 1 : ((pick < 10) ? 7 : 2 + $urandom_range(4));
         end
         if (cities != active_cities) begin
            set_city_count((cities == 1 && $urandom_range(1)) ? 0 : cities);
            active_cities = cities;
         end
         load_all_pairs(cities, len_mode_type'($urandom_range(2)));
         send_solve();
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_valid          = 1'b0;
      req_type           = ets_pkg::REQ_LOAD;
      req_from_city      = '0;
      req_to_city        = '0;
      req_edge_length    = '0;
      rsp_stall          = 1'b0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      hold_left          = 0;
      cycle_count        = 0;
      fault_count        = 0;
      useful_requests    = 0;
      solves_issued      = 0;
      tour_steps_checked = 0;
      city_count_reg     = int'(ets_pkg::CITY_COUNT_RESET);
      for (int a = 0; a < 16; a++)
         for (int b = 0; b < 16; b++)
            road_len[a][b] = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_count_solve();
      test_tie_order();
      test_count_extremes();
      test_backpressure();
      test_random_traffic();

      // Let the last solve drain, then give a load still in flight time to
      // finish, so that any stray response would still be caught.
      wait_for_tours();
      repeat (20) @(posedge clock);

      $display("Covered %0d requests, %0d of them solves over 1 to 16 cities,",
               useful_requests, solves_issued);
      $display("and checked %0d tour cities under four pacing phases and a long hold-off.",
               tour_steps_checked);
      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
